/* rtl/bsc_pkg.sv */
// Shared types and constants of the beat sensor classifier.
package bsc_pkg;

   // Field and accumulator widths.
   localparam int SAMPLE_W = 12;
   localparam int SUM_W = 20;
   localparam int DIV_CNT_W = $clog2(SUM_W + 1);

   // Saturation limits.
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'hFFF;
   localparam logic [SUM_W-1:0] SUM_MAX = 20'hFFFFF;

   // Threshold values after reset.
   localparam logic [SAMPLE_W-1:0] ACCENT_THR_RESET = 12'd3500;
   localparam logic [SAMPLE_W-1:0] TRACK_THR_RESET = 12'd3000;

   // Track row code for a beat with no row or a floating beat.
   localparam logic signed [2:0] TRACK_NONE = -3'sd1;

   // Request codes of the input word.
   typedef enum logic [2:0] {
      OP_BEGIN     = 3'd0,
      OP_ACCENT    = 3'd1,
      OP_TRACK     = 3'd2,
      OP_FIRST     = 3'd3,
      OP_SECOND    = 3'd4,
      OP_INTEGRATE = 3'd5
   } op_type;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_ACCENT_THR = 1'b0,
      CSR_TRACK_THR  = 1'b1
   } csr_index_type;

   // Decoded command handed from the front end to the back end.
   typedef struct packed {
      op_type              op;
      logic [3:0]          beat;
      logic [1:0]          row;
      logic [SAMPLE_W-1:0] sample;
   } cmd_type;

endpackage

/* rtl/bsc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/bsc_divider.sv */
// Restoring divider, one quotient bit per cycle, for the integrate walk.
module bsc_divider #(
   parameter int DIVISOR_W = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [bsc_pkg::SUM_W-1:0]  dividend,
   input  logic [DIVISOR_W-1:0]       divisor,
   output logic                       busy,
   output logic [bsc_pkg::SUM_W-1:0]  quotient
);

   logic                              busy_ff, busy_in;
   logic [bsc_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [bsc_pkg::SUM_W-1:0]         quo_ff, quo_in;
   logic [DIVISOR_W-1:0]              rem_ff, rem_in;
   logic [DIVISOR_W-1:0]              div_ff, div_in;
   logic [DIVISOR_W:0]                trial;
   logic                              fits;

   // Load on start, else one shift-subtract step on the partial remainder.
   always_comb begin
      trial = {rem_ff, quo_ff[bsc_pkg::SUM_W-1]};
      fits = (trial >= {1'b0, div_ff});
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = bsc_pkg::DIV_CNT_W'(bsc_pkg::SUM_W);
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? DIVISOR_W'(trial - {1'b0, div_ff}) : DIVISOR_W'(trial);
         quo_in = {quo_ff[bsc_pkg::SUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == bsc_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy = busy_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/bsc_front.sv */
// Front end: decodes and filters request words into a two-entry command queue.
module bsc_front #(
   parameter int BEATS = 16,
   parameter int TRACKS = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [2:0]                       req_type,
   input  logic [3:0]                       req_beat,
   input  logic [1:0]                       req_row,
   input  logic [bsc_pkg::SAMPLE_W-1:0]     req_sample,
   input  logic                             cmd_pop,
   output logic                             cmd_valid,
   output bsc_pkg::cmd_type                 cmd
);

   localparam logic [1:0] QueueDepth = 2'd2;

   logic [1:0]        fill_ff, fill_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic              wr_ptr_ff, wr_ptr_in;
   bsc_pkg::cmd_type  slot_ff [2];
   bsc_pkg::cmd_type  new_cmd;
   logic              beat_ok;
   logic              row_ok;
   logic              keep;
   logic              push;
   logic              pop;

   // Requests on missing beats or rows, and unknown codes, cause nothing and are dropped.
   always_comb begin
      beat_ok = (int'(req_beat) < BEATS);
      row_ok = (int'(req_row) < TRACKS);
      keep = 1'b0;
      unique case (req_type)
         bsc_pkg::OP_BEGIN, bsc_pkg::OP_INTEGRATE: keep = 1'b1;
         bsc_pkg::OP_ACCENT, bsc_pkg::OP_FIRST, bsc_pkg::OP_SECOND: keep = beat_ok;
         bsc_pkg::OP_TRACK: keep = beat_ok && row_ok;
         default: keep = 1'b0;
      endcase
      new_cmd.op = bsc_pkg::op_type'(req_type);
      new_cmd.beat = req_beat;
      new_cmd.row = req_row;
      new_cmd.sample = req_sample;
   end

   // Queue pointers and fill level.
   always_comb begin
      push = req_valid && !req_stall && keep;
      pop = cmd_pop && (fill_ff != 2'd0);
      fill_in = fill_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 2'd0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   assign req_stall = (fill_ff == QueueDepth);
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd = slot_ff[rd_ptr_ff];

endmodule

/* rtl/bsc_back.sv */
// Back end: executes queued commands on the beat state and runs the integrate walk.
module bsc_back #(
   parameter int BEATS = 16,
   parameter int MAX_SCANS = 255
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_valid,
   input  bsc_pkg::cmd_type                 cmd,
   output logic                             cmd_pop,
   input  logic [bsc_pkg::SAMPLE_W-1:0]     accent_thr,
   input  logic [bsc_pkg::SAMPLE_W-1:0]     track_thr,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [3:0]                       rsp_out_beat,
   output logic                             rsp_accented,
   output logic signed [2:0]                rsp_track_row,
   output logic [bsc_pkg::SAMPLE_W-1:0]     rsp_position,
   output logic                             rsp_last
);

   localparam int IdxW = (BEATS > 1) ? $clog2(BEATS) : 1;
   localparam int CntW = $clog2(MAX_SCANS + 1);
   localparam int SumW = bsc_pkg::SUM_W;
   localparam int SampW = bsc_pkg::SAMPLE_W;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_SUM      = 6'b000010,
      ST_INT_RD   = 6'b000100,
      ST_INT_DATA = 6'b001000,
      ST_INT_DIV  = 6'b010000,
      ST_INT_OUT  = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   bsc_pkg::cmd_type    cur_ff, cur_in;
   logic [IdxW-1:0]     walk_ff, walk_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic [BEATS-1:0]    accent_ff, accent_in;
   logic [BEATS-1:0]    seen_ff, seen_in;
   logic [BEATS-1:0]    sum_vld_ff, sum_vld_in;
   logic [SumW-1:0]     q_ff, q_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [3:0]          rsp_beat_ff, rsp_beat_in;
   logic                rsp_accent_ff, rsp_accent_in;
   logic signed [2:0]   rsp_track_ff, rsp_track_in;
   logic [SampW-1:0]    rsp_pos_ff, rsp_pos_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [IdxW-1:0]     cmd_idx;
   logic [IdxW-1:0]     cur_idx;
   logic                out_free;
   logic                is_last;

   logic                first_we, first_re;
   logic [SampW-1:0]    first_rd;
   logic                sum_we, sum_re;
   logic [IdxW-1:0]     sum_waddr, sum_raddr;
   logic [IdxW-1:0]     sum_rsel;
   logic [SumW-1:0]     sum_wdata, sum_rd, sum_cur;
   logic                trk_we, trk_re;
   logic [2:0]          trk_wdata, trk_rd;

   logic [SampW:0]      pair;
   logic [SumW:0]       total;

   logic                div_start, div_busy;
   logic [SumW-1:0]     div_quot;

   assign cmd_idx = IdxW'(cmd.beat);
   assign cur_idx = IdxW'(cur_ff.beat);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign is_last = (walk_ff == IdxW'(BEATS - 1));

   // Accumulator entries never written since reset read as zero.
   assign sum_rsel = (state_ff == ST_SUM) ? cur_idx : walk_ff;
   assign sum_cur = sum_vld_ff[sum_rsel] ? sum_rd : '0;

   // Average of the two opposing readings, added with saturation.
   always_comb begin
      pair = {1'b0, first_rd} + {1'b0, ~cur_ff.sample};
      total = {1'b0, sum_cur} + (SumW + 1)'(pair[SampW:1]);
   end

   // Command sequencer.
   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      walk_in = walk_ff;
      count_in = count_ff;
      accent_in = accent_ff;
      seen_in = seen_ff;
      sum_vld_in = sum_vld_ff;
      q_in = q_ff;
      cmd_pop = 1'b0;
      first_we = 1'b0;
      first_re = 1'b0;
      sum_we = 1'b0;
      sum_re = 1'b0;
      sum_waddr = walk_ff;
      sum_raddr = walk_ff;
      sum_wdata = q_ff;
      trk_we = 1'b0;
      trk_re = 1'b0;
      trk_wdata = bsc_pkg::TRACK_NONE;
      div_start = 1'b0;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_beat_in = rsp_beat_ff;
      rsp_accent_in = rsp_accent_ff;
      rsp_track_in = rsp_track_ff;
      rsp_pos_in = rsp_pos_ff;
      rsp_last_in = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cur_in = cmd;
               unique case (cmd.op)
                  bsc_pkg::OP_BEGIN: begin
                     accent_in = '0;
                     seen_in = '0;
                     if (count_ff < CntW'(MAX_SCANS)) begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  bsc_pkg::OP_ACCENT: begin
                     if (cmd.sample > accent_thr) begin
                        accent_in[cmd_idx] = 1'b1;
                     end
                  end
                  bsc_pkg::OP_TRACK: begin
                     // A second high row on the same beat marks it floating.
                     if (cmd.sample > track_thr) begin
                        trk_we = 1'b1;
                        trk_wdata = seen_ff[cmd_idx] ? bsc_pkg::TRACK_NONE : {1'b0, cmd.row};
                        seen_in[cmd_idx] = 1'b1;
                     end
                  end
                  bsc_pkg::OP_FIRST: begin
                     first_we = 1'b1;
                  end
                  bsc_pkg::OP_SECOND: begin
                     first_re = 1'b1;
                     sum_re = 1'b1;
                     sum_raddr = cmd_idx;
                     state_in = ST_SUM;
                  end
                  bsc_pkg::OP_INTEGRATE: begin
                     walk_in = '0;
                     state_in = ST_INT_RD;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SUM: begin
            sum_we = 1'b1;
            sum_waddr = cur_idx;
            sum_wdata = total[SumW] ? bsc_pkg::SUM_MAX : total[SumW-1:0];
            sum_vld_in[cur_idx] = 1'b1;
            state_in = ST_IDLE;
         end
         ST_INT_RD: begin
            sum_re = 1'b1;
            trk_re = 1'b1;
            state_in = ST_INT_DATA;
         end
         ST_INT_DATA: begin
            // A zero scan count leaves the accumulator as it is.
            if (count_ff != '0) begin
               div_start = 1'b1;
               state_in = ST_INT_DIV;
            end else begin
               q_in = sum_cur;
               state_in = ST_INT_OUT;
            end
         end
         ST_INT_DIV: begin
            if (!div_busy) begin
               q_in = div_quot;
               state_in = ST_INT_OUT;
            end
         end
         ST_INT_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_beat_in = 4'(walk_ff);
               rsp_accent_in = accent_ff[walk_ff];
               rsp_track_in = seen_ff[walk_ff] ? trk_rd : bsc_pkg::TRACK_NONE;
               rsp_pos_in = (q_ff > SumW'(bsc_pkg::SAMPLE_MAX)) ?
                            bsc_pkg::SAMPLE_MAX : q_ff[SampW-1:0];
               rsp_last_in = is_last;
               sum_we = 1'b1;
               sum_vld_in[walk_ff] = 1'b1;
               if (is_last) begin
                  count_in = CntW'(1);
                  state_in = ST_IDLE;
               end else begin
                  walk_in = walk_ff + 1'b1;
                  state_in = ST_INT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         accent_ff <= '0;
         seen_ff <= '0;
         sum_vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         accent_ff <= accent_in;
         seen_ff <= seen_in;
         sum_vld_ff <= sum_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      walk_ff <= walk_in;
      q_ff <= q_in;
      rsp_beat_ff <= rsp_beat_in;
      rsp_accent_ff <= rsp_accent_in;
      rsp_track_ff <= rsp_track_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Per-beat storage.
   bsc_ram #(.WIDTH(SampW), .DEPTH(BEATS)) first_ram (
      .clock   (clock),
      .wr_en   (first_we),
      .wr_addr (cmd_idx),
      .wr_data (cmd.sample),
      .rd_en   (first_re),
      .rd_addr (cmd_idx),
      .rd_data (first_rd)
   );

   bsc_ram #(.WIDTH(SumW), .DEPTH(BEATS)) sum_ram (
      .clock   (clock),
      .wr_en   (sum_we),
      .wr_addr (sum_waddr),
      .wr_data (sum_wdata),
      .rd_en   (sum_re),
      .rd_addr (sum_raddr),
      .rd_data (sum_rd)
   );

   bsc_ram #(.WIDTH(3), .DEPTH(BEATS)) track_ram (
      .clock   (clock),
      .wr_en   (trk_we),
      .wr_addr (cmd_idx),
      .wr_data (trk_wdata),
      .rd_en   (trk_re),
      .rd_addr (walk_ff),
      .rd_data (trk_rd)
   );

   bsc_divider #(.DIVISOR_W(CntW)) divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_cur),
      .divisor  (count_ff),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_beat = rsp_beat_ff;
   assign rsp_accented = rsp_accent_ff;
   assign rsp_track_row = rsp_track_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_last = rsp_last_ff;

endmodule

/* rtl/beat_sensor_classifier_unit.sv */
// Beat sensor classifier: thresholds, command queue front end and executing back end.
// Each request word enters a two-entry queue that stalls further requests while full;
// the back end executes one command at a time, taking an extra accumulate state for
// a second position reading. Integrate reads each beat's accumulator and track row,
// divides by the scan count one bit per cycle unless it is zero, and outputs a word.
// Synchronous active-high reset clears all marks, accumulators and the scan count
// at once and restores the thresholds to 3500 and 3000.
module beat_sensor_classifier_unit #(
   parameter int BEATS = 16,
   parameter int TRACKS = 4,
   parameter int MAX_SCANS = 255
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [2:0]                       req_type,
   input  logic [3:0]                       req_beat,
   input  logic [1:0]                       req_row,
   input  logic [bsc_pkg::SAMPLE_W-1:0]     req_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [3:0]                       rsp_out_beat,
   output logic                             rsp_accented,
   output logic signed [2:0]                rsp_track_row,
   output logic [bsc_pkg::SAMPLE_W-1:0]     rsp_position,
   output logic                             rsp_last,
   input  logic                             csr_wr_en,
   input  logic [0:0]                       csr_index,
   input  logic [bsc_pkg::SAMPLE_W-1:0]     csr_wr_data
);

   logic [bsc_pkg::SAMPLE_W-1:0] accent_thr_ff, accent_thr_in;
   logic [bsc_pkg::SAMPLE_W-1:0] track_thr_ff, track_thr_in;
   logic                         cmd_valid;
   logic                         cmd_pop;
   bsc_pkg::cmd_type             cmd;

   // Threshold registers.
   always_comb begin
      accent_thr_in = accent_thr_ff;
      track_thr_in = track_thr_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            bsc_pkg::CSR_ACCENT_THR: accent_thr_in = csr_wr_data;
            bsc_pkg::CSR_TRACK_THR:  track_thr_in = csr_wr_data;
            default:                 accent_thr_in = accent_thr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accent_thr_ff <= bsc_pkg::ACCENT_THR_RESET;
         track_thr_ff <= bsc_pkg::TRACK_THR_RESET;
      end else begin
         accent_thr_ff <= accent_thr_in;
         track_thr_ff <= track_thr_in;
      end
   end

   bsc_front #(.BEATS(BEATS), .TRACKS(TRACKS)) front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_type   (req_type),
      .req_beat   (req_beat),
      .req_row    (req_row),
      .req_sample (req_sample),
      .cmd_pop    (cmd_pop),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd)
   );

   bsc_back #(.BEATS(BEATS), .MAX_SCANS(MAX_SCANS)) back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop),
      .accent_thr    (accent_thr_ff),
      .track_thr     (track_thr_ff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_beat  (rsp_out_beat),
      .rsp_accented  (rsp_accented),
      .rsp_track_row (rsp_track_row),
      .rsp_position  (rsp_position),
      .rsp_last      (rsp_last)
   );

endmodule

/* rtl/bsc_checker.sv */
// Port-level checks of the beat sensor classifier, bound to the top level.
module bsc_checker #(
   parameter int BEATS = 16
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [3:0]                       rsp_out_beat,
   input logic                             rsp_accented,
   input logic signed [2:0]                rsp_track_row,
   input logic [bsc_pkg::SAMPLE_W-1:0]     rsp_position,
   input logic                             rsp_last
);

   // A stalled result word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_beat) &&
         $stable(rsp_accented) && $stable(rsp_track_row) &&
         $stable(rsp_position) && $stable(rsp_last))
      else $error("result word changed while stalled");

   // The final word of a walk belongs to the highest beat.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_out_beat == 4'(BEATS - 1))
      else $error("last flag on a beat other than the final one");

   // The track row is a real row or the none code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_track_row[2] == 1'b0) || (rsp_track_row == bsc_pkg::TRACK_NONE))
      else $error("track row out of range");

   // Reset leaves no result pending and the queue open.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("reset did not clear the handshakes");

endmodule

bind beat_sensor_classifier_unit bsc_checker #(.BEATS(BEATS)) port_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_beat  (rsp_out_beat),
   .rsp_accented  (rsp_accented),
   .rsp_track_row (rsp_track_row),
   .rsp_position  (rsp_position),
   .rsp_last      (rsp_last)
);
